>>> hw/rtl/mac_learning_table_with_aging_unit_defines.svh
// Assertion macros shared by the address table RTL.
`ifndef MAC_LEARNING_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MLTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MLTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/mlta_pkg.sv
// Shared types and constants for the address table with aging.
`default_nettype none

package mlta_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam logic [15:0] MAX_AGE_RST     = 16'd300;
  localparam logic [6:0]  COUNT_MAX       = 7'd127;

  typedef enum logic [1:0] {
    KIND_LEARN  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_SWEEP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic tick;
    logic scan_rd;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic addr_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/mlta_ctrl.sv
// Sequencer for clearing, scanning, committing and answering items.
`default_nettype none

`include "mac_learning_table_with_aging_unit_defines.svh"

module mlta_ctrl
  import mlta_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_ready,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.addr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (kind_t'(in_kind) == KIND_TICK) begin
            cmd.tick  = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.addr_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  `MLTA_ASSERT_IMP(a_load_when_free, cmd.load_out, sts.out_free)
  `MLTA_ASSERT_NXT(a_scan_after_accept, cmd.accept && !cmd.tick, state_r == ST_SCAN)
  `MLTA_ASSERT_IMP(a_tail_after_last, state_r == ST_TAIL, $past(sts.addr_last))

endmodule

`default_nettype wire

>>> hw/rtl/mlta_dpath.sv
// Entry memories, scan evaluation, counters and the result register.
`default_nettype none

`include "mac_learning_table_with_aging_unit_defines.svh"

module mlta_dpath
  import mlta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic [1:0]  in_kind,
  input  wire logic [47:0] in_mac_addr,
  input  wire logic [7:0]  in_port,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             out_hit,
  output logic [7:0]       out_port,
  output logic             out_status,
  output logic [6:0]       out_entry_count
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // entry stores
  logic        vld_mem  [TABLE_DEPTH];
  logic [47:0] mac_mem  [TABLE_DEPTH];
  logic [7:0]  port_mem [TABLE_DEPTH];
  logic [31:0] seen_mem [TABLE_DEPTH];

  logic [15:0]   max_age_r;
  logic [31:0]   seconds_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] addr_r;
  logic          eval_r;
  logic [AW-1:0] eval_addr_r;

  kind_t       kind_r;
  logic [47:0] key_mac_r;
  logic [7:0]  key_port_r;

  logic        rd_vld_r;
  logic [47:0] rd_mac_r;
  logic [7:0]  rd_port_r;
  logic [31:0] rd_seen_r;

  logic          match_fnd_r;
  logic [AW-1:0] match_idx_r;
  logic [7:0]    match_port_r;
  logic          free_fnd_r;
  logic [AW-1:0] free_idx_r;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [7:0]    out_port_r;
  logic          out_status_r;
  logic [6:0]    out_count_r;

  logic          addr_last;
  logic [31:0]   age;
  logic          expire;
  logic          hit_eval;
  logic          insert;
  logic          refresh;
  logic          vld_we;
  logic [AW-1:0] vld_waddr;
  logic          vld_wdata;
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic [31:0]   count_ext;

  assign addr_last = (addr_r == AW'(TABLE_DEPTH - 1));
  assign sts.addr_last = addr_last;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign age      = seconds_r - rd_seen_r;
  assign expire   = eval_r && (kind_r == KIND_SWEEP) && rd_vld_r && (age >= {16'd0, max_age_r});
  assign hit_eval = eval_r && rd_vld_r && (rd_mac_r == key_mac_r) && !match_fnd_r;
  assign refresh  = cmd.commit && (kind_r == KIND_LEARN) && match_fnd_r;
  assign insert   = cmd.commit && (kind_r == KIND_LEARN) && !match_fnd_r && free_fnd_r;

  // one write port on the valid store: clear pass, sweep kill, learn insert
  always_comb begin
    vld_we    = 1'b0;
    vld_waddr = addr_r;
    vld_wdata = 1'b0;
    if (cmd.clr_step) begin
      vld_we = 1'b1;
    end else if (expire) begin
      vld_we    = 1'b1;
      vld_waddr = eval_addr_r;
    end else if (insert) begin
      vld_we    = 1'b1;
      vld_waddr = free_idx_r;
      vld_wdata = 1'b1;
    end
  end

  assign ent_we    = refresh || insert;
  assign ent_waddr = match_fnd_r ? match_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
    if (insert) begin
      mac_mem[free_idx_r] <= key_mac_r;
    end
    if (ent_we) begin
      port_mem[ent_waddr] <= key_port_r;
      seen_mem[ent_waddr] <= seconds_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r  <= vld_mem[addr_r];
    rd_mac_r  <= mac_mem[addr_r];
    rd_port_r <= port_mem[addr_r];
    rd_seen_r <= seen_mem[addr_r];
  end

  always_comb begin
    count_nxt = count_r;
    if (expire) begin
      count_nxt = count_r - CW'(1);
    end else if (insert) begin
      count_nxt = count_r + CW'(1);
    end
  end

  assign count_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r   <= MAX_AGE_RST;
      seconds_r   <= '0;
      count_r     <= '0;
      addr_r      <= '0;
      eval_r      <= 1'b0;
      kind_r      <= KIND_LEARN;
      match_fnd_r <= 1'b0;
      free_fnd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_age_r <= cfg_wdata;
      end
      if (cmd.tick) begin
        seconds_r <= seconds_r + 32'd1;
      end
      count_r <= count_nxt;
      if (cmd.clr_step || cmd.scan_rd) begin
        addr_r <= addr_last ? '0 : addr_r + AW'(1);
      end
      eval_r <= cmd.scan_rd;
      if (cmd.accept) begin
        kind_r      <= kind_t'(in_kind);
        match_fnd_r <= 1'b0;
        free_fnd_r  <= 1'b0;
      end else if (eval_r) begin
        if (hit_eval) begin
          match_fnd_r <= 1'b1;
        end
        if (!rd_vld_r && !free_fnd_r) begin
          free_fnd_r <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    eval_addr_r <= addr_r;
    if (cmd.accept) begin
      key_mac_r  <= in_mac_addr;
      key_port_r <= in_port;
    end
    if (hit_eval) begin
      match_idx_r  <= eval_addr_r;
      match_port_r <= rd_port_r;
    end
    if (eval_r && !rd_vld_r && !free_fnd_r) begin
      free_idx_r <= eval_addr_r;
    end
    if (cmd.load_out) begin
      out_hit_r    <= ((kind_r == KIND_LEARN) || (kind_r == KIND_LOOKUP)) && match_fnd_r;
      out_port_r   <= ((kind_r == KIND_LOOKUP) && match_fnd_r) ? match_port_r : 8'd0;
      out_status_r <= (kind_r == KIND_LEARN) && !match_fnd_r && !free_fnd_r;
      out_count_r  <= (count_ext > 32'(COUNT_MAX)) ? COUNT_MAX : count_ext[6:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_port        = out_port_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  `MLTA_ASSERT_IMP(a_count_bound, 1'b1, count_ext <= 32'(TABLE_DEPTH))
  `MLTA_ASSERT_IMP(a_no_insert_full, insert, count_ext < 32'(TABLE_DEPTH))
  `MLTA_ASSERT_NXT(a_out_hold, out_valid_r && !out_ready, out_valid_r)

endmodule

`default_nettype wire

>>> hw/rtl/mac_learning_table_with_aging_unit.sv
// Top level of the switch address table with learning, lookup and aging.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid/in_ready   | in_kind, in_mac_addr, in_port
//   out     | output    | out_valid/out_ready | out_hit, out_port, out_status, out_entry_count
//   cfg     | input     | cfg_we              | cfg_wdata (max_age_sec)
//
// A tick goes from the transfer straight to its last step; learn, lookup and sweep
// first pass through the scan, a tail step and a commit step, as the entry memories
// have a single read port, which a scan walks one entry per cycle before the learn
// write is committed. After reset a clearing pass runs over the valid store;
// in_ready stays low during it, cfg writes are taken as ever.
// A finished result holds in the output register while out_ready is low; the
// next item is taken in the meantime and waits in its last step until the
// register frees.
`default_nettype none

module mac_learning_table_with_aging_unit
  import mlta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [47:0] in_mac_addr,
  input  wire logic [7:0]  in_port,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [7:0]       out_port,
  output logic             out_status,
  output logic [6:0]       out_entry_count
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: clear pass, scan walk, commit, result hand-off
  mlta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // memories, match and free search, aging compare, counters, output register
  mlta_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_mac_addr     (in_mac_addr),
    .in_port         (in_port),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_port        (out_port),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

>>> bench/mac_learning_table_with_aging_unit_tb.sv
// Self-checking testbench for the switch address table with learning, lookup and aging.
module mac_learning_table_with_aging_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlta_pkg::*;

  // Table depth as built, and the slowest item (scan over every entry plus commit).
  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int ITEM_CYCLES = DEPTH + 4;
  // Cycles without any transfer before the run is declared hung. The worst quiet
  // stretch is the clearing pass plus one full scan plus a receiver stall.
  localparam int STALL_LIMIT = 2000;
  localparam int NO_SLOT     = -1;
  localparam int POOL_SIZE   = 96;
  localparam int NUM_DIR     = 25;
  localparam int NUM_PHASES  = 5;

  // One result transfer, field for field.
  typedef struct packed {
    logic       hit;
    logic [7:0] port;
    logic       status;
    logic [6:0] count;
  } fdb_result_t;

  // One row of the directed table: either a lifetime write or an item. Rows with
  // typed set carry their expected result; the others go to the predictor.
  typedef struct packed {
    logic        is_cfg;
    logic [15:0] age;
    kind_t       kind;
    logic [47:0] mac;
    logic [7:0]  port;
    logic        typed;
    fdb_result_t want;
  } dir_row_t;

  // One random phase: lifetime, length, mix of kinds (sweeps take the rest),
  // size of the address pool drawn from, and idle percentage on both sides.
  typedef struct {
    logic [15:0] age;
    int          items;
    int          learn_pct;
    int          lookup_pct;
    int          tick_pct;
    int          pool;
    int          idle;
  } phase_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = 16'd0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind     = 2'd0;
  logic [47:0] in_mac_addr = 48'd0;
  logic [7:0]  in_port     = 8'd0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        out_hit;
  logic [7:0]  out_port;
  logic        out_status;
  logic [6:0]  out_entry_count;

  // Shadow copy of the table, the clock and the lifetime register.
  logic        mac_valid  [DEPTH];
  logic [47:0] mac_store  [DEPTH];
  logic [7:0]  port_store [DEPTH];
  logic [31:0] seen_store [DEPTH];
  logic [31:0] sec_now;
  logic [6:0]  live_count;
  logic [15:0] age_limit;

  fdb_result_t pending_results [$];
  logic [47:0] mac_pool [POOL_SIZE];
  int          fail_count   = 0;
  int          quiet_cycles = 0;
  int          idle_pct     = 31;

  dir_row_t dir_rows [NUM_DIR] = '{
    // empty table: lookup misses, first learns insert
    '{1'b0, 16'd0, KIND_LOOKUP, 48'h0000_0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LEARN,  48'h0000_0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd1}},
    '{1'b0, 16'd0, KIND_LEARN,  48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd2}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0, 7'd2}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'h0000_0000_0000, 8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0, 7'd2}},
    // refresh of a known address moves its port, count unchanged
    '{1'b0, 16'd0, KIND_LEARN,  48'h0000_0000_0000, 8'h5A, 1'b1, '{1'b1, 8'h00, 1'b0, 7'd2}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'h0000_0000_0000, 8'h00, 1'b1, '{1'b1, 8'h5A, 1'b0, 7'd2}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'h0000_0000_0001, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd2}},
    // one second is far below the reset lifetime: nothing ages out
    '{1'b0, 16'd0, KIND_TICK,   48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd2}},
    '{1'b0, 16'd0, KIND_SWEEP,  48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd2}},
    '{1'b0, 16'd0, KIND_LEARN,  48'hAAAA_AAAA_AAAA, 8'h55, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LEARN,  48'h5555_5555_5555, 8'hAA, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'hAAAA_AAAA_AAAA, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    // shortest lifetime: only the address refreshed this second survives
    '{1'b1, 16'd1, KIND_TICK,   48'h0000_0000_0000, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_TICK,   48'h0000_0000_0000, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LEARN,  48'h0000_0000_0000, 8'h3C, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_SWEEP,  48'h0000_0000_0000, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LOOKUP, 48'h0000_0000_0000, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    // zero lifetime: a sweep empties the table
    '{1'b1, 16'd0, KIND_TICK,   48'h0000_0000_0000, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_SWEEP,  48'h0000_0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd0}},
    // longest lifetime: a fresh entry survives a sweep
    '{1'b1, 16'hFFFF, KIND_TICK, 48'h0000_0000_0000, 8'h00, 1'b0, '{1'b0, 8'h00, 1'b0, 7'd0}},
    '{1'b0, 16'd0, KIND_LEARN,  48'h1234_5678_9ABC, 8'h81, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd1}},
    '{1'b0, 16'd0, KIND_TICK,   48'h0000_0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd1}},
    '{1'b0, 16'd0, KIND_SWEEP,  48'h0000_0000_0000, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 7'd1}}
  };

  phase_t phases [NUM_PHASES] = '{
    // short lifetime, small pool: steady churn of learns and removals
    '{16'd5,     220, 40, 30, 20, 40, 31},
    // longest lifetime, wide pool, no idling: fill the table and hit drops
    '{16'hFFFF,  260, 65, 25,  5, 96,  0},
    // shortest lifetime: drain the full table
    '{16'd1,     200, 35, 25, 25, 96, 31},
    // zero lifetime: every sweep clears
    '{16'd0,     100, 45, 30, 10, 24, 31},
    '{16'd12,    220, 40, 35, 15, 64, 31}
  };

  mac_learning_table_with_aging_unit #(
    .TABLE_DEPTH (DEPTH)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_mac_addr     (in_mac_addr),
    .in_port         (in_port),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_port        (out_port),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one item to the shadow table and return the result it must produce.
  function automatic fdb_result_t fdb_apply(kind_t kind, logic [47:0] mac, logic [7:0] port);
    fdb_result_t res;
    int          slot;
    int          free_idx;
    res      = '0;
    slot     = NO_SLOT;
    free_idx = NO_SLOT;
    // Walk downward so the last hit is the lowest-numbered slot.
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (mac_valid[i] && mac_store[i] == mac) slot = i;
      if (!mac_valid[i]) free_idx = i;
    end
    case (kind)
      KIND_LEARN: begin
        if (slot != NO_SLOT) begin
          port_store[slot] = port;
          seen_store[slot] = sec_now;
          res.hit          = 1'b1;
        end else if (free_idx != NO_SLOT) begin
          mac_valid[free_idx]  = 1'b1;
          mac_store[free_idx]  = mac;
          port_store[free_idx] = port;
          seen_store[free_idx] = sec_now;
          live_count++;
        end else begin
          res.status = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (slot != NO_SLOT) begin
          res.hit  = 1'b1;
          res.port = port_store[slot];
        end
      end
      KIND_TICK: sec_now++;
      default: begin
        // Age is taken modulo 2^32, so a wrapped clock still ages correctly.
        for (int i = 0; i < DEPTH; i++) begin
          if (mac_valid[i] && (sec_now - seen_store[i]) >= 32'(age_limit)) begin
            mac_valid[i] = 1'b0;
            live_count--;
          end
        end
      end
    endcase
    res.count = live_count;
    return res;
  endfunction

  // Append one expected result behind those already waiting.
  task automatic enqueue_expect(input fdb_result_t res);
    pending_results = {pending_results, res};
  endtask

  // Present one item, hold it until the transfer, then queue its expected result.
  // Called at a rising edge; leaves off at the edge of the transfer.
  task automatic send_item(input kind_t kind, input logic [47:0] mac, input logic [7:0] port,
                           input logic typed, input fdb_result_t want);
    fdb_result_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_mac_addr <= mac;
    in_port     <= port;
    do @(posedge clk); while (!in_ready);
    predicted = fdb_apply(kind, mac, port);
    enqueue_expect(typed ? want : predicted);
  endtask

  // Drain every outstanding result, then write the lifetime register.
  task automatic write_age_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    age_limit  = value;
  endtask

  // Receiver: drop ready at random, never while the quiet phase runs.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    fdb_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit: expected %0d, got %0d", want.hit, out_hit);
          fail_count++;
        end
        if (out_port !== want.port) begin
          $error("out_port: expected %0d, got %0d", want.port, out_port);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_entry_count !== want.count) begin
          $error("out_entry_count: expected %0d, got %0d", want.count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    kind_t       kind;
    logic [47:0] mac;
    int          pick;
    for (int i = 0; i < DEPTH; i++) begin
      mac_valid[i]  = 1'b0;
      mac_store[i]  = '0;
      port_store[i] = '0;
      seen_store[i] = '0;
    end
    sec_now    = '0;
    live_count = '0;
    age_limit  = MAX_AGE_RST;
    foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom(), $urandom()});

    // Hold reset, then release at an edge; the clearing pass shows as in_ready low.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, refresh, miss, and each aging corner.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_age_limit(dir_rows[i].age);
      end else begin
        send_item(dir_rows[i].kind, dir_rows[i].mac, dir_rows[i].port,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases. Each starts with a lifetime write on a drained block, which
    // also serves as the pause for all results. Most addresses come from a pool
    // so learns refresh and lookups hit; one in ten is fresh noise.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_age_limit(phases[p].age);
      idle_pct = phases[p].idle;
      for (int n = 0; n < phases[p].items; n++) begin
        pick = $urandom_range(99);
        if (pick < phases[p].learn_pct) begin
          kind = KIND_LEARN;
        end else if (pick < phases[p].learn_pct + phases[p].lookup_pct) begin
          kind = KIND_LOOKUP;
        end else if (pick < phases[p].learn_pct + phases[p].lookup_pct + phases[p].tick_pct) begin
          kind = KIND_TICK;
        end else begin
          kind = KIND_SWEEP;
        end
        if ($urandom_range(9) == 0) begin
          mac = 48'({$urandom(), $urandom()});
        end else begin
          mac = mac_pool[$urandom_range(phases[p].pool - 1)];
        end
        send_item(kind, mac, 8'($urandom_range(255)), 1'b0, '0);
      end
    end
    idle_pct = 31;

    // Drain, then give the block one full item time to show any stray result.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
